// File: hw/rtl/rbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the ring buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int CAP_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ_AT    = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/rbd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_cell
// One ring slot plus one stage of the read chain toward cell zero.
// ----------------------------------------------------------------------------
module rbd_cell #(
    parameter int IDX_W = 4,
    parameter int W     = 32,
    parameter int INDEX = 0
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [W-1:0]     wr_data,
    input  logic [IDX_W-1:0] rd_sel,
    input  logic [W-1:0]     bus_in,
    output logic [W-1:0]     bus_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [W-1:0] slot_reg;
    logic [W-1:0] slot_next;
    logic [W-1:0] bus_reg;
    logic [W-1:0] bus_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (wr_en && (wr_idx == MY_IDX))
        begin
            slot_next = wr_data;
        end
        // selected cell injects its slot, the others pass the neighbor on
        bus_next = (rd_sel == MY_IDX) ? slot_reg : bus_in;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        bus_reg  <= bus_next;
    end

    assign bus_out = bus_reg;

endmodule
`default_nettype wire

// File: hw/rtl/ring_buffer_deque_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_deque_top
// Double-ended queue over a row of slot cells with a configurable ring size.
//
// channel   direction  handshake             fields
// command   in         start / busy          command, element_data, position
// result    out        done (one cycle)      success, read_data, fill_count,
//                                            is_empty, is_full
// config    in         cfg_we                cfg_data (capacity in use)
//
// push, pop, clear and unknown codes leave busy low; a new item may follow
// in the next cycle and the result strobes in the cycle after acceptance.
// read at walks position steps around the ring (ST_WALK), then waits while
// the slot ripples down the cell chain (ST_SHIFT) and takes it from cell
// zero (ST_FETCH), with busy high meanwhile.
// reset empties the deque and sets the capacity to 16; slot contents are
// not cleared. a capacity write also empties the deque.
// the receiver cannot stall; done is high for exactly one cycle per item.
// ----------------------------------------------------------------------------
module ring_buffer_deque_top #(
    parameter int DEPTH        = 16,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [rbd_pkg::CMD_W-1:0]  command,
    input  logic [rbd_pkg::DATA_W-1:0] element_data,
    input  logic [rbd_pkg::POS_W-1:0]  position,
    input  logic                      cfg_we,
    input  logic [rbd_pkg::CAP_W-1:0]  cfg_data,
    output logic                      done,
    output logic                      success,
    output logic [rbd_pkg::DATA_W-1:0] read_data,
    output logic [rbd_pkg::CAP_W-1:0]  fill_count,
    output logic                      is_empty,
    output logic                      is_full
);

    import rbd_pkg::*;

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int STORE_W = (ELEMENT_BITS < DATA_W) ? ELEMENT_BITS : DATA_W;
    localparam int CMP_W   = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_FETCH = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic [IDX_W-1:0]     front_reg, front_next;
    logic [IDX_W-1:0]     back_reg, back_next;
    logic [CAP_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     walk_idx_reg, walk_idx_next;
    logic [POS_W-1:0]     walk_cnt_reg, walk_cnt_next;
    logic [IDX_W-1:0]     shift_cnt_reg, shift_cnt_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 done_reg, done_next;
    logic                 success_reg, success_next;
    logic [DATA_W-1:0]    read_data_reg, read_data_next;
    logic [CAP_W-1:0]     fill_count_reg, fill_count_next;
    logic                 is_empty_reg, is_empty_next;
    logic                 is_full_reg, is_full_next;

    logic [CAP_W-1:0]     eff_cap;
    logic                 full;
    logic                 accept;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [STORE_W-1:0]   wr_data;
    logic [STORE_W-1:0]   bus [DEPTH];

    function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] idx,
                                                  input logic [CAP_W-1:0] cap);
        logic [CMP_W-1:0] nxt;
        nxt = CMP_W'(idx) + CMP_W'(1);
        if (nxt >= CMP_W'(cap))
        begin
            return '0;
        end
        return nxt[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] step_bwd(input logic [IDX_W-1:0] idx,
                                                  input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] top;
        top = cap - CAP_W'(1);
        if (idx == '0)
        begin
            return IDX_W'(top);
        end
        return idx - IDX_W'(1);
    endfunction

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CAP_W'(1);
        end
        else if (int'(cap_reg) > DEPTH)
        begin
            eff_cap = CAP_W'(DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign full    = (count_reg >= eff_cap);
    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign wr_data = element_data[STORE_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        count_next      = count_reg;
        walk_idx_next   = walk_idx_reg;
        walk_cnt_next   = walk_cnt_reg;
        shift_cnt_next  = shift_cnt_reg;
        pos_next        = pos_reg;
        done_next       = 1'b0;
        success_next    = success_reg;
        read_data_next  = read_data_reg;
        fill_count_next = fill_count_reg;
        is_empty_next   = is_empty_reg;
        is_full_next    = is_full_reg;
        wr_en           = 1'b0;
        wr_idx          = front_reg;

        priority if (cfg_we)
        begin
            cap_next   = cfg_data;
            front_next = '0;
            back_next  = '0;
            count_next = '0;
        end
        else if (state_reg == ST_IDLE)
        begin
            if (accept)
            begin
                success_next   = 1'b0;
                read_data_next = '0;
                unique case (command)
                    CMD_PUSH_FRONT:
                    begin
                        if (!full)
                        begin
                            front_next = step_bwd(front_reg, eff_cap);
                            if (count_reg == '0)
                            begin
                                back_next = front_next;
                            end
                            wr_en        = 1'b1;
                            wr_idx       = front_next;
                            count_next   = count_reg + CAP_W'(1);
                            success_next = 1'b1;
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (!full)
                        begin
                            back_next = step_fwd(back_reg, eff_cap);
                            if (count_reg == '0)
                            begin
                                front_next = back_next;
                            end
                            wr_en        = 1'b1;
                            wr_idx       = back_next;
                            count_next   = count_reg + CAP_W'(1);
                            success_next = 1'b1;
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (count_reg != '0)
                        begin
                            front_next   = step_fwd(front_reg, eff_cap);
                            count_next   = count_reg - CAP_W'(1);
                            success_next = 1'b1;
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (count_reg != '0)
                        begin
                            back_next    = step_bwd(back_reg, eff_cap);
                            count_next   = count_reg - CAP_W'(1);
                            success_next = 1'b1;
                        end
                    end
                    CMD_READ_AT:
                    begin
                        state_next    = ST_WALK;
                        walk_idx_next = front_reg;
                        walk_cnt_next = position;
                        pos_next      = position;
                    end
                    CMD_CLEAR:
                    begin
                        front_next   = '0;
                        back_next    = '0;
                        count_next   = '0;
                        success_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                if (command != CMD_READ_AT)
                begin
                    done_next       = 1'b1;
                    fill_count_next = count_next;
                    is_empty_next   = (count_next == '0);
                    is_full_next    = (count_next == eff_cap);
                end
            end
        end
        else
        begin
            unique case (state_reg)
                ST_WALK:
                begin
                    if (walk_cnt_reg == '0)
                    begin
                        state_next     = ST_SHIFT;
                        shift_cnt_next = walk_idx_reg;
                    end
                    else
                    begin
                        walk_idx_next = step_fwd(walk_idx_reg, eff_cap);
                        walk_cnt_next = walk_cnt_reg - POS_W'(1);
                    end
                end
                ST_SHIFT:
                begin
                    if (shift_cnt_reg == '0)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        shift_cnt_next = shift_cnt_reg - IDX_W'(1);
                    end
                end
                ST_FETCH:
                begin
                    state_next      = ST_IDLE;
                    done_next       = 1'b1;
                    success_next    = (CAP_W'(pos_reg) < count_reg);
                    read_data_next  = DATA_W'(bus[0]);
                    fill_count_next = count_reg;
                    is_empty_next   = (count_reg == '0);
                    is_full_next    = (count_reg == eff_cap);
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CAP_W'(16);
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_idx_reg   <= walk_idx_next;
        walk_cnt_reg   <= walk_cnt_next;
        shift_cnt_reg  <= shift_cnt_next;
        pos_reg        <= pos_next;
        success_reg    <= success_next;
        read_data_reg  <= read_data_next;
        fill_count_reg <= fill_count_next;
        is_empty_reg   <= is_empty_next;
        is_full_reg    <= is_full_next;
    end

    // slot cells, read chain runs from the last cell down to cell zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [STORE_W-1:0] bus_in;
        if (i == DEPTH - 1)
        begin : g_last
            assign bus_in = '0;
        end
        else
        begin : g_mid
            assign bus_in = bus[i+1];
        end
        rbd_cell #(
            .IDX_W (IDX_W),
            .W     (STORE_W),
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_idx  (wr_idx),
            .wr_data (wr_data),
            .rd_sel  (walk_idx_reg),
            .bus_in  (bus_in),
            .bus_out (bus[i])
        );
    end

    assign done       = done_reg;
    assign success    = success_reg;
    assign read_data  = read_data_reg;
    assign fill_count = fill_count_reg;
    assign is_empty   = is_empty_reg;
    assign is_full    = is_full_reg;

    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= eff_cap)
        else $error("fill count above capacity");

    a_index_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (CMP_W'(front_reg) < CMP_W'(eff_cap)) && (CMP_W'(back_reg) < CMP_W'(eff_cap)))
        else $error("ring index outside capacity");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_read_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !cfg_we && (command == CMD_READ_AT)) |=> (busy && !done))
        else $error("read at did not start a walk");

    a_short_cmd_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !cfg_we && (command != CMD_READ_AT)) |=> (done && !busy))
        else $error("single cycle item gave no result");

endmodule
`default_nettype wire

// File: test/ring_buffer_deque_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque_top_test
// Self-checking bench for the ring buffer deque. A short table of directed
// commands covers the empty and full edges, the capacity extremes, clear and
// the spare command codes. Random phases at several ring sizes follow. Every
// accepted item is run through a local deque model, and each done strobe is
// checked field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module ring_buffer_deque_top_test;

    import rbd_pkg::*;

    localparam int RING_SLOTS = 16;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic              success;
        logic [DATA_W-1:0] read_data;
        logic [CAP_W-1:0]  fill_count;
        logic              is_empty;
        logic              is_full;
    } deque_res_t;

    typedef enum logic { ROW_ITEM, ROW_CAP } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic [CAP_W-1:0]  cap;
        bit                typed;
        deque_res_t        res;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] element_data;
    logic [POS_W-1:0]  position;
    logic              cfg_we;
    logic [CAP_W-1:0]  cfg_data;
    logic              done;
    logic              success;
    logic [DATA_W-1:0] read_data;
    logic [CAP_W-1:0]  fill_count;
    logic              is_empty;
    logic              is_full;

    // local deque model
    logic [DATA_W-1:0] slot_mem [RING_SLOTS];
    bit                slot_valid [RING_SLOTS];
    int                head_slot;
    int                tail_slot;
    int                occupancy;
    logic [CAP_W-1:0]  ring_size_reg;

    deque_res_t pending_results [$];
    stim_row_t  directed_rows [$];
    deque_res_t observed_res;
    deque_res_t oldest_res;
    int         error_count;

    ring_buffer_deque_top #(
        .DEPTH        (RING_SLOTS),
        .ELEMENT_BITS (DATA_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .element_data (element_data),
        .position     (position),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .done         (done),
        .success      (success),
        .read_data    (read_data),
        .fill_count   (fill_count),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int ring_size();
        int c;
        c = int'(ring_size_reg);
        if (c < 1)
            c = 1;
        if (c > RING_SLOTS)
            c = RING_SLOTS;
        return c;
    endfunction

    function automatic void deque_reset();
        for (int i = 0; i < RING_SLOTS; i++)
        begin
            slot_mem[i]   = '0;
            slot_valid[i] = 1'b0;
        end
        head_slot     = 0;
        tail_slot     = 0;
        occupancy     = 0;
        ring_size_reg = 5'd16;
    endfunction

    function automatic void deque_resize(logic [CAP_W-1:0] v);
        ring_size_reg = v;
        head_slot     = 0;
        tail_slot     = 0;
        occupancy     = 0;
    endfunction

    function automatic deque_res_t deque_step(logic [CMD_W-1:0] cmd,
                                              logic [DATA_W-1:0] data,
                                              logic [POS_W-1:0] pos);
        deque_res_t r;
        int         cap;
        int         slot;
        bit         was_full;
        r        = '0;
        cap      = ring_size();
        was_full = (occupancy >= cap);
        case (cmd)
            CMD_PUSH_FRONT:
            begin
                if (!was_full)
                begin
                    head_slot = (head_slot % cap == 0) ? cap - 1 : head_slot % cap - 1;
                    if (occupancy == 0)
                        tail_slot = head_slot;
                    slot_mem[head_slot]   = data;
                    slot_valid[head_slot] = 1'b1;
                    occupancy++;
                    r.success = 1'b1;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (!was_full)
                begin
                    tail_slot = (tail_slot % cap + 1 >= cap) ? 0 : tail_slot % cap + 1;
                    if (occupancy == 0)
                        head_slot = tail_slot;
                    slot_mem[tail_slot]   = data;
                    slot_valid[tail_slot] = 1'b1;
                    occupancy++;
                    r.success = 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                if (occupancy != 0)
                begin
                    head_slot = (head_slot % cap + 1 >= cap) ? 0 : head_slot % cap + 1;
                    occupancy--;
                    r.success = 1'b1;
                end
            end
            CMD_POP_BACK:
            begin
                if (occupancy != 0)
                begin
                    tail_slot = (tail_slot % cap == 0) ? cap - 1 : tail_slot % cap - 1;
                    occupancy--;
                    r.success = 1'b1;
                end
            end
            CMD_READ_AT:
            begin
                slot        = (head_slot % cap + int'(pos)) % cap;
                r.read_data = slot_mem[slot];
                r.success   = (int'(pos) < occupancy);
            end
            CMD_CLEAR:
            begin
                head_slot = 0;
                tail_slot = 0;
                occupancy = 0;
                r.success = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.fill_count = occupancy[CAP_W-1:0];
        r.is_empty   = (occupancy == 0);
        r.is_full    = (occupancy == cap);
        return r;
    endfunction

    function automatic deque_res_t mk_res(logic ok, logic [DATA_W-1:0] rd,
                                          logic [CAP_W-1:0] fill, logic emp, logic full);
        deque_res_t r;
        r.success    = ok;
        r.read_data  = rd;
        r.fill_count = fill;
        r.is_empty   = emp;
        r.is_full    = full;
        return r;
    endfunction

    function automatic void add_cmd(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                                    logic [POS_W-1:0] pos);
        stim_row_t row;
        row.kind  = ROW_ITEM;
        row.cmd   = cmd;
        row.data  = data;
        row.pos   = pos;
        row.cap   = '0;
        row.typed = 1'b0;
        row.res   = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_typed(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                                      logic [POS_W-1:0] pos, deque_res_t res);
        add_cmd(cmd, data, pos);
        directed_rows[$].typed = 1'b1;
        directed_rows[$].res   = res;
    endfunction

    function automatic void add_cap(logic [CAP_W-1:0] v);
        add_cmd(CMD_CLEAR, '0, '0);
        directed_rows[$].kind = ROW_CAP;
        directed_rows[$].cap  = v;
    endfunction

    // hold start low until every pending result has come back
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        deque_resize(v);
    endtask

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                             logic [POS_W-1:0] pos, bit typed, deque_res_t typed_res);
        deque_res_t predicted;
        start        <= 1'b1;
        command      <= cmd;
        element_data <= data;
        position     <= pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = deque_step(cmd, data, pos);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic maybe_idle(bit quiet);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic pick_item(int push_w, output logic [CMD_W-1:0] cmd,
                             output logic [DATA_W-1:0] data, output logic [POS_W-1:0] pos);
        int cap;
        int roll;
        int tries;
        bit found;
        cap  = ring_size();
        roll = $urandom_range(0, 99);
        data = $urandom;
        if ($urandom_range(0, 15) == 0)
            data = $urandom_range(0, 1) ? '1 : '0;
        pos = POS_W'($urandom_range(0, 15));
        if (roll < push_w)
        begin
            if ($urandom_range(0, 1))
                cmd = CMD_PUSH_BACK;
            else
                cmd = CMD_PUSH_FRONT;
        end
        else if (roll < 72)
        begin
            if ($urandom_range(0, 1))
                cmd = CMD_POP_BACK;
            else
                cmd = CMD_POP_FRONT;
        end
        else if (roll < 93)
        begin
            if (occupancy > 0 && $urandom_range(0, 3) != 0)
                pos = POS_W'($urandom_range(0, occupancy - 1));
            // never read a slot that has not been written since reset
            found = slot_valid[(head_slot % cap + int'(pos)) % cap];
            tries = 0;
            while (!found && tries < 16)
            begin
                pos   = POS_W'($urandom_range(0, 15));
                found = slot_valid[(head_slot % cap + int'(pos)) % cap];
                tries++;
            end
            if (found)
                cmd = CMD_READ_AT;
            else
                cmd = CMD_PUSH_BACK;
        end
        else if (roll < 96)
            cmd = CMD_CLEAR;
        else if ($urandom_range(0, 1))
            cmd = CMD_SPARE_6;
        else
            cmd = CMD_SPARE_7;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            observed_res = {success, read_data, fill_count, is_empty, is_full};
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: ok=%0d rd=%h fill=%0d e=%0d f=%0d",
                             success, read_data, fill_count, is_empty, is_full);
            end
            else
            begin
                oldest_res = pending_results.pop_front();
                if (observed_res.success !== oldest_res.success
                    || observed_res.read_data !== oldest_res.read_data
                    || observed_res.fill_count !== oldest_res.fill_count
                    || observed_res.is_empty !== oldest_res.is_empty
                    || observed_res.is_full !== oldest_res.is_full)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: exp ok=%0d rd=%h fill=%0d e=%0d f=%0d %s",
                                 oldest_res.success, oldest_res.read_data,
                                 oldest_res.fill_count, oldest_res.is_empty,
                                 oldest_res.is_full, "");
                    if (error_count <= 10)
                        $display("          got ok=%0d rd=%h fill=%0d e=%0d f=%0d",
                                 success, read_data, fill_count, is_empty, is_full);
                end
            end
        end
    end

    initial
    begin
        logic [CAP_W-1:0]  phase_caps [8];
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  pos;
        int                push_w;
        stim_row_t         row;

        error_count  = 0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        command      <= CMD_CLEAR;
        element_data <= '0;
        position     <= '0;
        cfg_we       <= 1'b0;
        cfg_data     <= '0;
        deque_reset();

        // empty deque after reset, capacity 16
        add_typed(CMD_POP_FRONT, 32'h0000_0000, 4'd0, mk_res(0, 32'h0, 5'd0, 1, 0));
        add_typed(CMD_POP_BACK, 32'hFFFF_FFFF, 4'd15, mk_res(0, 32'h0, 5'd0, 1, 0));
        add_typed(CMD_SPARE_6, 32'h1234_5678, 4'd3, mk_res(0, 32'h0, 5'd0, 1, 0));
        add_typed(CMD_SPARE_7, 32'hFFFF_FFFF, 4'd15, mk_res(0, 32'h0, 5'd0, 1, 0));
        // push from both ends, starting on the empty deque
        add_typed(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0, mk_res(1, 32'h0, 5'd1, 0, 0));
        add_typed(CMD_PUSH_BACK, 32'h0000_0000, 4'd0, mk_res(1, 32'h0, 5'd2, 0, 0));
        add_typed(CMD_READ_AT, 32'h0, 4'd0, mk_res(1, 32'hFFFF_FFFF, 5'd2, 0, 0));
        add_typed(CMD_READ_AT, 32'h0, 4'd1, mk_res(1, 32'h0, 5'd2, 0, 0));
        add_cmd(CMD_PUSH_BACK, 32'hA5A5_A5A5, 4'd0);
        add_cmd(CMD_PUSH_FRONT, 32'h5A5A_5A5A, 4'd0);
        add_cmd(CMD_READ_AT, 32'h0, 4'd3);
        add_cmd(CMD_READ_AT, 32'h0, 4'd2);
        add_cmd(CMD_POP_BACK, 32'h0, 4'd0);
        add_cmd(CMD_POP_FRONT, 32'h0, 4'd0);
        // read past fill count
        add_cmd(CMD_READ_AT, 32'h0, 4'd2);
        add_typed(CMD_CLEAR, 32'h0, 4'd0, mk_res(1, 32'h0, 5'd0, 1, 0));
        add_cmd(CMD_PUSH_BACK, 32'h1234_5678, 4'd0);
        // single slot ring
        add_cap(5'd1);
        add_typed(CMD_PUSH_FRONT, 32'hDEAD_BEEF, 4'd0, mk_res(1, 32'h0, 5'd1, 0, 1));
        add_typed(CMD_PUSH_BACK, 32'h0000_0001, 4'd0, mk_res(0, 32'h0, 5'd1, 0, 1));
        add_typed(CMD_READ_AT, 32'h0, 4'd0, mk_res(1, 32'hDEAD_BEEF, 5'd1, 0, 1));
        add_typed(CMD_READ_AT, 32'h0, 4'd15, mk_res(0, 32'hDEAD_BEEF, 5'd1, 0, 1));
        add_typed(CMD_POP_BACK, 32'h0, 4'd0, mk_res(1, 32'h0, 5'd0, 1, 0));
        // capacity zero behaves as one
        add_cap(5'd0);
        add_typed(CMD_PUSH_BACK, 32'h8000_0001, 4'd0, mk_res(1, 32'h0, 5'd1, 0, 1));
        // capacity above depth behaves as depth
        add_cap(5'd31);
        add_cmd(CMD_PUSH_FRONT, 32'hFFFF_0000, 4'd0);
        add_cmd(CMD_POP_FRONT, 32'h0, 4'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CAP)
                write_capacity(row.cap);
            else
            begin
                send_item(row.cmd, row.data, row.pos, row.typed, row.res);
                maybe_idle(1'b0);
            end
        end

        phase_caps[0] = 5'd16;
        phase_caps[1] = 5'd1;
        phase_caps[2] = 5'd31;
        phase_caps[3] = 5'd0;
        phase_caps[4] = 5'd2;
        phase_caps[5] = CAP_W'($urandom_range(1, 16));
        phase_caps[6] = CAP_W'($urandom_range(0, 31));
        phase_caps[7] = 5'd16;

        for (int phase = 0; phase < 8; phase++)
        begin
            write_capacity(phase_caps[phase]);
            push_w = (phase % 2 == 0) ? 60 : $urandom_range(25, 50);
            for (int n = 0; n < 50; n++)
            begin
                pick_item(push_w, cmd, data, pos);
                send_item(cmd, data, pos, 1'b0, '0);
                if (phase == 3 && n == 25)
                    wait_idle();
                else
                    maybe_idle(phase == 7);
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
